/* sv/bfris_pkg.sv */
// ----------------------------------------------------------------------------
// bfris_pkg
// Request and response types shared by the best-fit slot selector files.
// ----------------------------------------------------------------------------
package bfris_pkg;

    // Fixed field widths of the request and response payloads
    localparam int SLOT_FIELD_W = 4;
    localparam int BOUND_W      = 16;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [BOUND_W-1:0]        low_bound;
        logic [BOUND_W-1:0]        high_bound;
        logic [BOUND_W-1:0]        request_size;
        logic                      lock_on_match;
    } t_req;

    typedef struct packed {
        logic                      found;
        logic [SLOT_FIELD_W-1:0]   chosen_slot;
    } t_rsp;

endpackage

/* sv/bfris_chan_if.sv */
// ----------------------------------------------------------------------------
// bfris_chan_if
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface bfris_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/bfris_table.sv */
// ----------------------------------------------------------------------------
// bfris_table
// Slot bound memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfris_table #(
    parameter int SLOTS     = 16,
    parameter int SIZE_BITS = 16,
    parameter int SLOT_W    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [SLOT_W-1:0]    i_wr_addr,
    input  logic [SIZE_BITS-1:0] i_wr_lo,
    input  logic [SIZE_BITS-1:0] i_wr_hi,
    input  logic [SLOT_W-1:0]    i_rd_addr,
    output logic [SIZE_BITS-1:0] o_rd_lo,
    output logic [SIZE_BITS-1:0] o_rd_hi
);

    logic [2*SIZE_BITS-1:0] r_mem [SLOTS];
    logic [2*SIZE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_hi, i_wr_lo};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_lo = r_rd_data[SIZE_BITS-1:0];
    assign o_rd_hi = r_rd_data[2*SIZE_BITS-1:SIZE_BITS];

endmodule

/* sv/best_fit_range_instance_select.sv */
// ----------------------------------------------------------------------------
// best_fit_range_instance_select
// Best-fit slot selector: keeps per-slot request-size ranges and picks the
// available slot with the tightest upper bound that holds a request size.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload   Meaning
//  i_req     in   t_req     add a slot range (op = add) or query a best fit
//  o_rsp     out  t_rsp     one response per request: found, chosen_slot
//
//  An add request completes in the cycle it is accepted; its response sits in
//  the output register on the next cycle. A query scans the bound memory one
//  slot per cycle through a single compare unit, a rate set by the one memory
//  read port; the result waits in ST_FINISH until the output register is free.
//  Reset (i_rst_n low, synchronous) clears the available marks, the sequencer
//  and the output valid flag; the bound memory is not cleared.
//  While a query runs, i_req.ready is low. A response held by o_rsp.ready low
//  blocks new requests until it drains.
// ----------------------------------------------------------------------------
module best_fit_range_instance_select #(
    parameter int SLOTS     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfris_chan_if.sink    i_req,
    bfris_chan_if.source  o_rsp
);
    import bfris_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // Wide enough to hold both the slot field and the slot count itself
    localparam int IDX_W  = ((SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state                 r_state;
    logic [SLOTS-1:0]       r_avail;       // one available mark per slot
    logic [SIZE_BITS-1:0]   r_req_size;
    logic                   r_lock;
    logic                   r_issue;       // read address still being issued
    logic [SLOT_W-1:0]      r_idx;         // read address sent to the memory
    logic                   r_rd_vld;      // memory data valid this cycle
    logic [SLOT_W-1:0]      r_rd_idx;      // slot the memory data belongs to
    logic                   r_hit;
    logic [SIZE_BITS-1:0]   r_best_hi;
    logic [SLOT_W-1:0]      r_best;
    logic                   r_out_vld;
    t_rsp                   r_out;

    t_req                   w_req;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_out_load;
    logic [IDX_W-1:0]       w_slot_ext;
    logic                   w_slot_ok;
    logic                   w_wr_en;
    logic [SIZE_BITS-1:0]   w_rd_lo;
    logic [SIZE_BITS-1:0]   w_rd_hi;
    logic                   w_match;
    logic                   w_last_issue;
    logic                   w_last_eval;

    assign w_req      = i_req.data;
    assign w_out_free = !r_out_vld || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_req.valid && i_req.ready;

    // A new response enters the output register on an add or at scan end
    assign w_out_load = (w_accept && (w_req.op == OP_ADD))
                        || ((r_state == ST_FINISH) && w_out_free);

    // Adds beyond the slot count are acknowledged with found low and dropped
    assign w_slot_ext = IDX_W'(w_req.slot);
    assign w_slot_ok  = w_slot_ext < IDX_W'(SLOTS);
    assign w_wr_en    = w_accept && (w_req.op == OP_ADD) && w_slot_ok;

    bfris_table #(
        .SLOTS     (SLOTS),
        .SIZE_BITS (SIZE_BITS),
        .SLOT_W    (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot_ext[SLOT_W-1:0]),
        .i_wr_lo   (SIZE_BITS'(w_req.low_bound)),
        .i_wr_hi   (SIZE_BITS'(w_req.high_bound)),
        .i_rd_addr (r_idx),
        .o_rd_lo   (w_rd_lo),
        .o_rd_hi   (w_rd_hi)
    );

    // Shared compare unit: range check plus best-so-far test. A tie on the
    // upper bound goes to the later, higher slot since the scan runs upward.
    assign w_match = r_rd_vld && r_avail[r_rd_idx]
                     && (w_rd_lo <= r_req_size) && (r_req_size <= w_rd_hi)
                     && (!r_hit || (w_rd_hi <= r_best_hi));

    assign w_last_issue = r_idx == SLOT_W'(SLOTS - 1);
    assign w_last_eval  = r_rd_vld && (r_rd_idx == SLOT_W'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_avail   <= '0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // Load a new response, or drop the one just taken
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            // Memory read data is registered; these carry its valid flag and slot
            r_rd_vld <= r_issue;
            r_rd_idx <= r_idx;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_req.op == OP_ADD) begin
                            if (w_slot_ok) begin
                                r_avail[w_slot_ext[SLOT_W-1:0]] <= 1'b1;
                            end
                            r_out.found       <= w_slot_ok;
                            r_out.chosen_slot <= w_req.slot;
                        end else begin
                            r_req_size <= SIZE_BITS'(w_req.request_size);
                            r_lock     <= w_req.lock_on_match;
                            r_idx      <= '0;
                            r_issue    <= 1'b1;
                            r_hit      <= 1'b0;
                            r_state    <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    // Advance the read address until the last slot is issued
                    if (r_issue) begin
                        if (w_last_issue) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + SLOT_W'(1);
                        end
                    end
                    if (w_match) begin
                        r_hit     <= 1'b1;
                        r_best_hi <= w_rd_hi;
                        r_best    <= r_rd_idx;
                    end
                    if (w_last_eval) begin
                        r_state <= ST_FINISH;
                    end
                end

                ST_FINISH: begin
                    // Hold the result until the output register is free
                    if (w_out_free) begin
                        r_out.found       <= r_hit;
                        r_out.chosen_slot <= r_hit ? SLOT_FIELD_W'(r_best) : '0;
                        if (r_hit && r_lock) begin
                            r_avail[r_best] <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the best-fit slot selector. A short table of
// directed requests covers empty tables, extreme bounds, inverted ranges,
// ties, locking and overwrites. Random add/query traffic follows. Every
// response is checked against a typed answer or the shadow slot model,
// under random idle bursts on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfris_pkg::*;

    localparam int SLOT_COUNT    = 16;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int QUIET_TAIL    = 200;   // last random requests sent with no idling
    localparam int HOLD_CYCLES   = 200;   // long response hold-off
    localparam int DRAIN_CYCLES  = 40;    // settle time after the last expected response
    localparam int STALL_LIMIT   = 2000;  // watchdog limit on a run with no handshake at all

    // One directed row: request fields, and a typed response where the
    // answer is obvious; rows with fixed_rsp = 0 use the shadow model.
    typedef struct packed {
        t_op                     op;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [BOUND_W-1:0]      low_bound;
        logic [BOUND_W-1:0]      high_bound;
        logic [BOUND_W-1:0]      request_size;
        logic                    lock_on_match;
        logic                    fixed_rsp;
        logic                    found;
        logic [SLOT_FIELD_W-1:0] chosen_slot;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    // op, slot, low, high, size, lock, fixed, found, chosen
    t_dir_row dir_table [DIR_ROWS] = '{
        // empty table: every query misses
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 1'b0, 4'd0},
        // full-range slot at index 0, zero-width slot at index 15
        '{OP_ADD,   4'd0,  16'd0,     16'hFFFF,  16'd0,     1'b0, 1'b1, 1'b1, 4'd0},
        '{OP_ADD,   4'd15, 16'd0,     16'd0,     16'hFFFF,  1'b1, 1'b1, 1'b1, 4'd15},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, 1'b1, 1'b1, 4'd15},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'hFFFF,  1'b0, 1'b1, 1'b1, 4'd0},
        // inverted range never matches
        '{OP_ADD,   4'd7,  16'd100,   16'd50,    16'd0,     1'b0, 1'b1, 1'b1, 4'd7},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd75,    1'b0, 1'b0, 1'b0, 4'd0},
        // equal upper bounds: highest index wins, then lock them away
        '{OP_ADD,   4'd3,  16'd10,    16'd200,   16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_ADD,   4'd9,  16'd20,    16'd200,   16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd50,    1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd50,    1'b1, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd50,    1'b1, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd50,    1'b1, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd50,    1'b0, 1'b0, 1'b0, 4'd0},
        // add over a locked slot makes it available again
        '{OP_ADD,   4'd9,  16'd30,    16'd40,    16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd35,    1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'hFFFF,  1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_ADD,   4'd5,  16'hFFFF,  16'hFFFF,  16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'hFFFF,  1'b1, 1'b0, 1'b0, 4'd0},
        // add over an available slot rewrites its bounds
        '{OP_ADD,   4'd15, 16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd0,     1'b1, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_ADD,   4'd10, 16'hFFFF,  16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 4'd0},
        '{OP_QUERY, 4'd0,  16'd0,     16'd0,     16'h8000,  1'b0, 1'b0, 1'b0, 4'd0}
    };

    logic i_clk;
    logic i_rst_n;

    bfris_chan_if #(.T(t_req)) req_if ();
    bfris_chan_if #(.T(t_rsp)) rsp_if ();

    best_fit_range_instance_select #(
        .SLOTS     (SLOT_COUNT),
        .SIZE_BITS (BOUND_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow slot table; never-written slots read as zero bounds, which the
    // best-fit search never consults, since only written slots can be available.
    logic [BOUND_W-1:0]    shadow_low  [SLOT_COUNT];
    logic [BOUND_W-1:0]    shadow_high [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] shadow_avail;
    logic [SLOT_COUNT-1:0] shadow_locked;

    t_rsp rsp_expected [$];

    // Typed response that travels with the request currently offered
    logic cur_fixed;
    t_rsp cur_fixed_rsp;

    int  error_count;
    int  stall_cycles;
    int  n_adds, n_queries, n_hits, n_locks;
    bit  idle_on;
    bit  hold_request;

    // ------------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Best-fit prediction: apply one request to the shadow table and return
    // the response it must produce.
    // ------------------------------------------------------------------------
    function automatic t_rsp best_fit_answer(t_req r);
        t_rsp               rsp;
        bit                 hit;
        logic [BOUND_W-1:0] best_high;
        int                 best;
        rsp       = '0;
        hit       = 1'b0;
        best_high = '0;
        best      = 0;
        if (r.op == OP_ADD) begin
            // slot field is 4 bits, so every index is in range
            shadow_low[r.slot]   = r.low_bound;
            shadow_high[r.slot]  = r.high_bound;
            shadow_avail[r.slot] = 1'b1;
            rsp.found            = 1'b1;
            rsp.chosen_slot      = r.slot;
            n_adds++;
        end else begin
            n_queries++;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (shadow_avail[i] && shadow_low[i] <= r.request_size &&
                    r.request_size <= shadow_high[i]) begin
                    // <= lets a later index take an equal upper bound
                    if (!hit || shadow_high[i] <= best_high) begin
                        hit       = 1'b1;
                        best_high = shadow_high[i];
                        best      = i;
                    end
                end
            end
            if (hit) begin
                if (r.lock_on_match) begin
                    shadow_avail[best]  = 1'b0;
                    shadow_locked[best] = 1'b1;
                    n_locks++;
                end
                rsp.found       = 1'b1;
                rsp.chosen_slot = best[SLOT_FIELD_W-1:0];
                n_hits++;
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. An accepted request
    // queues its expected response; an accepted response is checked against
    // the oldest one waiting.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp predicted;
        t_rsp oldest;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                moved     = 1'b1;
                predicted = best_fit_answer(req_if.data);
                // typed rows stand on their own; the model still tracks state
                if (cur_fixed) begin
                    rsp_expected.push_back(cur_fixed_rsp);
                end else begin
                    rsp_expected.push_back(predicted);
                end
            end
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                moved = 1'b1;
                if (rsp_expected.size() == 0) begin
                    $error("response with none expected: found %0d chosen_slot %0d",
                           rsp_if.data.found, rsp_if.data.chosen_slot);
                    error_count++;
                end else begin
                    oldest = rsp_expected.pop_front();
                    if (rsp_if.data.found !== oldest.found) begin
                        $error("found: expected %0d, actual %0d",
                               oldest.found, rsp_if.data.found);
                        error_count++;
                    end
                    if (rsp_if.data.chosen_slot !== oldest.chosen_slot) begin
                        $error("chosen_slot: expected %0d, actual %0d",
                               oldest.chosen_slot, rsp_if.data.chosen_slot);
                        error_count++;
                    end
                end
            end
            // count cycles in which nothing moves on either channel
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when the monitor's stall count reaches STALL_LIMIT; it counts handshake-free cycles
    // ------------------------------------------------------------------------
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 STALL_LIMIT, rsp_expected.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side: ready changes at the falling edge. Drop ready in random
    // bursts while idling is on, and once for a long hold-off when the stimulus
    // asks for one.
    // ------------------------------------------------------------------------
    initial begin
        int burst;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 3);
                rsp_if.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side: offer one request at the falling edge, with an optional
    // idle burst first, and hold it until it is accepted. Valid stays high
    // between back-to-back requests.
    // ------------------------------------------------------------------------
    task automatic offer_request(t_req r, logic fixed, t_rsp fixed_rsp);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.data   <= r;
        cur_fixed     <= fixed;
        cur_fixed_rsp <= fixed_rsp;
        do begin
            @(posedge i_clk);
        end while (req_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_req r;
        t_rsp typed;
        int   idx;
        int   span;
        int   mode;
        bit   picked;

        // every input known from time zero
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        cur_fixed     = 1'b0;
        cur_fixed_rsp = '0;
        shadow_avail  = '0;
        shadow_locked = '0;
        error_count   = 0;
        n_adds        = 0;
        n_queries     = 0;
        n_hits        = 0;
        n_locks       = 0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            shadow_low[i]  = '0;
            shadow_high[i] = '0;
        end

        // hold reset, then release it at a falling edge
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table
        foreach (dir_table[n]) begin
            r               = '0;
            r.op            = dir_table[n].op;
            r.slot          = dir_table[n].slot;
            r.low_bound     = dir_table[n].low_bound;
            r.high_bound    = dir_table[n].high_bound;
            r.request_size  = dir_table[n].request_size;
            r.lock_on_match = dir_table[n].lock_on_match;
            typed.found       = dir_table[n].found;
            typed.chosen_slot = dir_table[n].chosen_slot;
            offer_request(r, dir_table[n].fixed_rsp, typed);
        end

        // long hold-off on the response side while requests keep coming,
        // so the output register fills and the input stalls
        hold_request = 1'b1;

        typed = '0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // idle in windows, with quiet stretches and a quiet tail
            idle_on = (k < RANDOM_ITEMS - QUIET_TAIL) && ((k / 150) % 3 != 2);

            // randomize every field, then shape the ones that matter
            r.op            = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_QUERY;
            r.slot          = SLOT_FIELD_W'($urandom_range(0, SLOT_COUNT - 1));
            r.low_bound     = BOUND_W'($urandom_range(0, 16'hFFFF));
            r.high_bound    = BOUND_W'($urandom_range(0, 16'hFFFF));
            r.request_size  = BOUND_W'($urandom_range(0, 16'hFFFF));
            r.lock_on_match = ($urandom_range(0, 2) == 0);

            if (r.op == OP_ADD) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) begin
                    // keep the fully random bounds, inverted or not
                end else if (mode == 1) begin
                    r.low_bound  = '0;
                    r.high_bound = 16'hFFFF;
                end else if (mode == 2) begin
                    // reuse an existing upper bound to provoke ties
                    idx          = $urandom_range(0, SLOT_COUNT - 1);
                    r.high_bound = shadow_high[idx];
                    r.low_bound  = BOUND_W'($urandom_range(0, r.high_bound));
                end else begin
                    span         = $urandom_range(0, 2000);
                    r.high_bound = (r.low_bound + span > 16'hFFFF) ? 16'hFFFF
                                                                   : BOUND_W'(r.low_bound + span);
                end
            end else if ($urandom_range(0, 3) != 0) begin
                // aim the size inside the range of some available slot
                idx    = $urandom_range(0, SLOT_COUNT - 1);
                picked = 1'b0;
                for (int j = 0; j < SLOT_COUNT && !picked; j++) begin
                    if (shadow_avail[(idx + j) % SLOT_COUNT] &&
                        shadow_low[(idx + j) % SLOT_COUNT] <=
                        shadow_high[(idx + j) % SLOT_COUNT]) begin
                        idx    = (idx + j) % SLOT_COUNT;
                        picked = 1'b1;
                    end
                end
                if (picked) begin
                    r.request_size = BOUND_W'(shadow_low[idx] +
                        $urandom_range(0, shadow_high[idx] - shadow_low[idx]));
                end
            end else if ($urandom_range(0, 3) == 0) begin
                r.request_size = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            end

            offer_request(r, 1'b0, typed);
        end

        // stop offering, drain every outstanding response
        req_if.valid <= 1'b0;
        cur_fixed    <= 1'b0;
        idle_on       = 1'b0;
        while (rsp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d adds and %0d queries (%0d hits, %0d locks), %0d directed rows",
                 n_adds, n_queries, n_hits, n_locks, DIR_ROWS);
        $display("random idling on both channels plus a %0d-cycle response hold-off",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
